// File: hw/rtl/complementary_tilt_filter_top_macros.svh
// Assertion macros for the complementary tilt filter
`ifndef COMPLEMENTARY_TILT_FILTER_TOP_MACROS_SVH
`define COMPLEMENTARY_TILT_FILTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctf assertion failed");

// next-cycle implication, disabled in reset
`define CTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctf assertion failed");

`endif

// File: hw/rtl/ctf_pkg.sv
// Package for the complementary tilt filter: constants, microcode and tables
package ctf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TABLE_LEN           = 24;
  localparam int ITER_W              = $clog2(TABLE_LEN);
  localparam int PC_W                = 3;

  localparam logic [0:0] CFG_GYRO_GAIN   = 1'b0;
  localparam logic [0:0] CFG_GYRO_WEIGHT = 1'b1;

  localparam logic [15:0] GAIN_RST   = 16'd20460;
  localparam logic [16:0] WEIGHT_RST = 17'd64225;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic [PC_W-1:0] PC_FETCH = 3'd0;
  localparam logic [PC_W-1:0] PC_ITER  = 3'd1;
  localparam logic [PC_W-1:0] PC_GMUL  = 3'd2;
  localparam logic [PC_W-1:0] PC_GSUM  = 3'd3;
  localparam logic [PC_W-1:0] PC_WMUL  = 3'd4;
  localparam logic [PC_W-1:0] PC_AMUL  = 3'd5;
  localparam logic [PC_W-1:0] PC_BLEND = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ITER,
    OP_GMUL,
    OP_GSUM,
    OP_WMUL,
    OP_AMUL,
    OP_BLEND
  } op_t;

  // hold condition: the step repeats while it is true
  typedef enum logic [1:0] {
    C_NONE,
    C_IN,
    C_ITER,
    C_OUT
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] next;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      PC_FETCH: c = '{op: OP_LOAD,  cond: C_IN,   next: PC_ITER};
      PC_ITER:  c = '{op: OP_ITER,  cond: C_ITER, next: PC_GMUL};
      PC_GMUL:  c = '{op: OP_GMUL,  cond: C_NONE, next: PC_GSUM};
      PC_GSUM:  c = '{op: OP_GSUM,  cond: C_NONE, next: PC_WMUL};
      PC_WMUL:  c = '{op: OP_WMUL,  cond: C_NONE, next: PC_AMUL};
      PC_AMUL:  c = '{op: OP_AMUL,  cond: C_NONE, next: PC_BLEND};
      PC_BLEND: c = '{op: OP_BLEND, cond: C_OUT,  next: PC_FETCH};
      default:  c = '{op: OP_NOP,   cond: C_NONE, next: PC_FETCH};
    endcase
    return c;
  endfunction

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic signed [33:0] atan_lut(input logic [ITER_W-1:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489089;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58671;
      5'd15:   v = 34'sd29335;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/complementary_tilt_filter_top.sv
// Complementary tilt filter top level: microcoded CORDIC and blend datapath
// Sequence per item: FETCH accepts it, ITER runs the CORDIC steps, then GMUL, GSUM, WMUL,
// AMUL and BLEND; in_stall is high outside FETCH, so no new item is taken until BLEND is done. The shared
// CORDIC step unit iterates once per cycle, then one shared 18x30 multiplier runs 3 passes.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset (synchronous, rst_n low): angle cleared, gain and weight restored, no item pending.
`include "complementary_tilt_filter_top_macros.svh"

module complementary_tilt_filter_top #(
  parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [28:0] out_tilt_angle
);

  localparam int NSTEP = (CORDIC_STEPS > ctf_pkg::TABLE_LEN) ? ctf_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;
  localparam logic [ctf_pkg::ITER_W-1:0] ITER_LAST = ctf_pkg::ITER_W'(NSTEP - 1);
  localparam int SH = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [33:0] RND_Z = 34'sd1 <<< (SH - 1);
  localparam logic signed [47:0] RND_P = 48'sd1 <<< (SH - 1);
  localparam logic signed [33:0] Z180  = 34'sd3019898880;
  localparam logic signed [48:0] ANG_MAX = 49'sd268435455;
  localparam logic signed [48:0] ANG_MIN = -49'sd268435456;

  function automatic logic signed [28:0] sat29(input logic signed [48:0] v);
    logic signed [28:0] r;
    if (v > ANG_MAX) r = ANG_MAX[28:0];
    else if (v < ANG_MIN) r = ANG_MIN[28:0];
    else r = v[28:0];
    return r;
  endfunction

  logic [ctf_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [ctf_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [15:0]                gain_r;
  logic [16:0]                weight_r;
  logic signed [28:0]         fused_r, fused_nxt;
  logic signed [33:0]         x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                       zero_r, zero_nxt;
  logic signed [15:0]         gy_r, gy_nxt;
  logic signed [29:0]         acc_r, acc_nxt;
  logic signed [28:0]         g_r, g_nxt;
  logic signed [47:0]         prod_r, prod_nxt, sum_r, sum_nxt;

  ctf_pkg::ctrl_t ctrl;
  logic           hold;
  logic           in_accept;

  logic signed [33:0] ax_ext, az_ext, xs, ys, at;
  logic signed [33:0] z_rnd_sum, z_rnd;
  logic signed [47:0] p_rnd_sum, p_rnd;
  logic signed [48:0] gsum, bsum, bsh;
  logic [16:0]        w_eff;
  logic signed [17:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [47:0] mul_p;

  assign ctrl      = ctf_pkg::ucode(pc_r);
  assign in_stall  = (pc_r != ctf_pkg::PC_FETCH);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_tilt_angle = fused_r;

  always_comb begin
    case (ctrl.cond)
      ctf_pkg::C_NONE: hold = 1'b0;
      ctf_pkg::C_IN:   hold = !in_valid;
      ctf_pkg::C_ITER: hold = (iter_r != ITER_LAST);
      ctf_pkg::C_OUT:  hold = out_valid_r && out_stall;
      default:         hold = 1'b0;
    endcase
    pc_nxt = hold ? pc_r : ctrl.next;
  end

  assign w_eff  = (weight_r > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : weight_r;
  assign ax_ext = {{2{in_accel_x[15]}}, in_accel_x, 16'b0};
  assign az_ext = {{2{in_accel_z[15]}}, in_accel_z, 16'b0};
  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign at     = ctf_pkg::atan_lut(iter_r);

  assign z_rnd_sum = z_r + RND_Z;
  assign z_rnd     = z_rnd_sum >>> SH;
  assign p_rnd_sum = prod_r + RND_P;
  assign p_rnd     = p_rnd_sum >>> SH;
  assign gsum      = {{20{fused_r[28]}}, fused_r} + {p_rnd[47], p_rnd};
  assign bsum      = {sum_r[47], sum_r} + {prod_r[47], prod_r} + 49'sd32768;
  assign bsh       = bsum >>> 16;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      ctf_pkg::OP_GMUL: begin
        mul_a = {2'b00, gain_r};
        mul_b = {{14{gy_r[15]}}, gy_r};
      end
      ctf_pkg::OP_WMUL: begin
        mul_a = {1'b0, w_eff};
        mul_b = {g_r[28], g_r};
      end
      ctf_pkg::OP_AMUL: begin
        mul_a = {1'b0, ctf_pkg::WEIGHT_ONE - w_eff};
        mul_b = acc_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    zero_nxt      = zero_r;
    gy_nxt        = gy_r;
    iter_nxt      = iter_r;
    acc_nxt       = acc_r;
    g_nxt         = g_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    fused_nxt     = fused_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (ctrl.op)
      ctf_pkg::OP_LOAD: begin
        if (in_accept) begin
          zero_nxt = (in_accel_x == 16'sd0) && (in_accel_z == 16'sd0);
          gy_nxt   = in_gyro_y;
          iter_nxt = '0;
          if (in_accel_z[15]) begin
            x_nxt = -az_ext;
            y_nxt = -ax_ext;
            z_nxt = in_accel_x[15] ? -Z180 : Z180;
          end else begin
            x_nxt = az_ext;
            y_nxt = ax_ext;
            z_nxt = '0;
          end
        end
      end
      ctf_pkg::OP_ITER: begin
        iter_nxt = iter_r + 1'b1;
        if (y_r > 34'sd0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end
      end
      ctf_pkg::OP_GMUL: begin
        acc_nxt  = zero_r ? 30'sd0 : z_rnd[29:0];
        prod_nxt = mul_p;
      end
      ctf_pkg::OP_GSUM: begin
        g_nxt = sat29(gsum);
      end
      ctf_pkg::OP_WMUL: begin
        prod_nxt = mul_p;
      end
      ctf_pkg::OP_AMUL: begin
        sum_nxt  = prod_r;
        prod_nxt = mul_p;
      end
      ctf_pkg::OP_BLEND: begin
        if (!hold) begin
          fused_nxt     = sat29(bsh);
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ctf_pkg::PC_FETCH;
      out_valid_r <= 1'b0;
      fused_r     <= '0;
      gain_r      <= ctf_pkg::GAIN_RST;
      weight_r    <= ctf_pkg::WEIGHT_RST;
      iter_r      <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      fused_r     <= fused_nxt;
      iter_r      <= iter_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ctf_pkg::CFG_GYRO_GAIN:   gain_r   <= cfg_wdata[15:0];
          ctf_pkg::CFG_GYRO_WEIGHT: weight_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
    gy_r   <= gy_nxt;
    acc_r  <= acc_nxt;
    g_r    <= g_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  `CTF_ASSERT_NEXT(a_load_starts_iter, in_accept, (pc_r == ctf_pkg::PC_ITER) && (iter_r == '0))
  `CTF_ASSERT_NOW(a_iter_bound, pc_r == ctf_pkg::PC_ITER, iter_r <= ITER_LAST)
  `CTF_ASSERT_NEXT(a_angle_held, out_valid_r && out_stall, $stable(fused_r) && out_valid_r)
  `CTF_ASSERT_NOW(a_zero_accel, (pc_r == ctf_pkg::PC_GSUM) && zero_r, acc_r == 30'sd0)

endmodule

// File: dv/complementary_tilt_filter_top_test.sv
// Self-checking testbench for the complementary tilt filter top level
`timescale 1ns / 100ps

module complementary_tilt_filter_top_test;

  localparam int     FRAC_SHIFT = 24 - ctf_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int     ATAN_LEN   = 24;
  localparam longint HALF_TURN  = 64'sd180 * 64'sd16777216;
  localparam longint ANGLE_HI   = 64'sd268435455;
  localparam longint ANGLE_LO   = -64'sd268435456;
  localparam longint UNITY      = 64'sd65536;
  localparam int     IDLE_LIMIT = 4000;

  // atan(2^-i) in 2^-24 degree
  localparam longint ATAN_DEG [ATAN_LEN] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  localparam int NUM_DIRECTED = 17;
  localparam logic signed [15:0] DIRECTED [NUM_DIRECTED][3] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh8000, 16'sh0000},
    '{16'sh0000, 16'shFFFF, 16'sh0000},
    '{16'sh7FFF, 16'sh0000, 16'sh0000},
    '{16'sh8000, 16'sh0000, 16'sh0000},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
    '{16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7FFF, 16'sh8000, 16'sh0000},
    '{16'sh8000, 16'sh7FFF, 16'sh0000},
    '{16'sh0001, 16'sh0001, 16'sh0001},
    '{16'shFFFF, 16'shFFFF, 16'shFFFF},
    '{16'shFFFF, 16'sh0000, 16'sh7FFF},
    '{16'sh0001, 16'sh8000, 16'sh8000},
    '{16'sh0000, 16'sh0001, 16'sh0000},
    '{16'sh0000, 16'sh7FFF, 16'sh0000},
    '{16'sh0064, 16'shFF9C, 16'sh0000},
    '{16'shFF9C, 16'shFF9C, 16'sh0000}
  };

  class tilt_tracker;
    logic [15:0]       gain;
    logic [16:0]       weight;
    longint            angle;
    logic signed [28:0] angles_due[$];
    int                mismatches;

    function new();
      gain       = ctf_pkg::GAIN_RST;
      weight     = ctf_pkg::WEIGHT_RST;
      angle      = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [0:0] idx, logic [16:0] data);
      if (idx == ctf_pkg::CFG_GYRO_GAIN) begin
        gain = data[15:0];
      end else if (idx == ctf_pkg::CFG_GYRO_WEIGHT) begin
        weight = data;
      end
    endfunction

    function longint clamp(longint v);
      if (v > ANGLE_HI) return ANGLE_HI;
      if (v < ANGLE_LO) return ANGLE_LO;
      return v;
    endfunction

    function longint round_to_frac(longint v);
      if (FRAC_SHIFT == 0) return v;
      return (v + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    endfunction

    // four-quadrant atan2(ax, az) in 2^-24 degree
    function longint tilt_of_accel(longint ax, longint az);
      longint x, y, z, xs, ys;
      int     steps, i;
      x = az * 65536;
      y = ax * 65536;
      z = 0;
      if (ax == 0 && az == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN : -HALF_TURN;
        x = -x;
        y = -y;
      end
      steps = (ctf_pkg::CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : ctf_pkg::CORDIC_STEPS_DEF;
      for (i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_DEG[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_DEG[i];
        end
      end
      return z;
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] az,
                              logic signed [15:0] gy);
      longint accel_ang, inc, gyro_ang, w, mix;
      accel_ang = round_to_frac(tilt_of_accel(ax, az));
      inc       = round_to_frac(longint'(gy) * longint'(gain));
      gyro_ang  = clamp(angle + inc);
      w         = (weight > 17'd65536) ? UNITY : longint'(weight);
      mix       = (w * gyro_ang + (UNITY - w) * accel_ang + 64'sd32768) >>> 16;
      angle     = clamp(mix);
      angles_due.push_back(angle[28:0]);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_angle(logic signed [28:0] got);
      logic signed [28:0] want;
      if (angles_due.size() == 0) begin
        report_mismatch($sformatf("tilt angle %0d with no sample pending", got));
      end else begin
        want = angles_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf("tilt angle got %0d want %0d", got, want));
      end
    endtask

    function int pending();
      return angles_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = ctf_pkg::CFG_GYRO_GAIN;
  logic [16:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_z = '0;
  logic signed [15:0] in_gyro_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [28:0] out_tilt_angle;

  tilt_tracker tracker;
  int          samples_taken = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  complementary_tilt_filter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_accel_x     (in_accel_x),
    .in_accel_z     (in_accel_z),
    .in_gyro_y      (in_gyro_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tilt_angle (out_tilt_angle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_sample(in_accel_x, in_accel_z, in_gyro_y);
        samples_taken++;
      end
      if (out_valid && !out_stall) tracker.check_angle(out_tilt_angle);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stall segments plus two long hold-offs
  initial begin
    int mode, seg, holds;
    holds = 0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(posedge clk);
        if (holds < 2 && samples_taken >= ((holds == 0) ? 150 : 480)) begin
          out_stall <= 1'b1;
          repeat (400) @(posedge clk);
          holds++;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic logic signed [15:0] pick_corner();
    case ($urandom_range(0, 4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'shFFFF;
      3:       return 16'sh0001;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 16'sh0000;
      1:       return pick_corner();
      2, 3:    return 16'($urandom_range(0, 400) - 200);
      default: return r[15:0];
    endcase
  endfunction

  // drift pushes the integrated angle one way, toward saturation
  function automatic logic signed [15:0] pick_rate(int drift);
    logic signed [15:0] mag;
    if (drift != 0 && $urandom_range(0, 99) < 85) begin
      mag = 16'($urandom_range(30000, 32767));
      return (drift > 0) ? mag : -mag;
    end
    return pick_sample();
  endfunction

  task automatic offer(logic signed [15:0] ax, logic signed [15:0] az,
                       logic signed [15:0] gy);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_z <= az;
    in_gyro_y  <= gy;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [16:0] gain_word, logic [16:0] weight_word);
    cfg_we    <= 1'b1;
    cfg_index <= ctf_pkg::CFG_GYRO_GAIN;
    cfg_wdata <= gain_word;
    @(posedge clk);
    tracker.set_register(ctf_pkg::CFG_GYRO_GAIN, gain_word);
    cfg_index <= ctf_pkg::CFG_GYRO_WEIGHT;
    cfg_wdata <= weight_word;
    @(posedge clk);
    tracker.set_register(ctf_pkg::CFG_GYRO_WEIGHT, weight_word);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count, int drift);
    repeat (count) offer(pick_sample(), pick_sample(), pick_rate(drift));
  endtask

  task automatic run_phase(logic [16:0] gain_word, logic [16:0] weight_word,
                           int count, int drift);
    settle();
    write_regs(gain_word, weight_word);
    random_items(count, drift);
  endtask

  initial begin
    int k;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gain and weight, corner samples first
    for (k = 0; k < NUM_DIRECTED; k++)
      offer(DIRECTED[k][0], DIRECTED[k][1], DIRECTED[k][2]);
    random_items(80, 0);

    run_phase(17'h1FFFF, 17'd65536, 100, 1);
    run_phase(17'd65535, 17'h1FFFF, 100, -1);
    run_phase(17'd0, 17'd0, 80, 0);
    run_phase(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)), 80, 0);
    run_phase(17'(ctf_pkg::GAIN_RST), 17'd65537, 80, 1);
    run_phase(17'd1, 17'd65535, 80, 0);
    run_phase(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)), 80,
              int'($urandom_range(0, 2)) - 1);

    settle();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
